>>> hdl/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Shared widths, operation codes and the table entry type of the
// multiset count table.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int KIND_WIDTH  = 2;
    localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
    localparam int USED_WIDTH  = $clog2(TABLE_DEPTH + 1);

    localparam logic [KIND_WIDTH-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_DEL = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_ASK = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [USED_WIDTH-1:0]  USED_FULL = USED_WIDTH'(TABLE_DEPTH);

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [COUNT_WIDTH-1:0] count;
    } t_entry;

endpackage

`default_nettype wire

>>> hdl/mct_if.sv
// ----------------------------------------------------------------------------
// mct_if
// Valid/ready channels of the multiset count table: the operation channel
// and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mct_in_if import mct_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic        [KIND_WIDTH-1:0]  kind;
    logic signed [KEY_WIDTH-1:0]   key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface mct_out_if import mct_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          ever_added;
    logic        [COUNT_WIDTH-1:0] count;
    logic                          table_full;

    modport source (output valid, output ever_added, output count, output table_full,
                    input ready);
    modport sink   (input valid, input ever_added, input count, input table_full,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/multiset_count_table.sv
// ----------------------------------------------------------------------------
// multiset_count_table
// Keyed occurrence-count table: add, delete and ask on signed 32-bit keys,
// with one stored key compared per cycle against the requested key.
// ----------------------------------------------------------------------------
// search: the scan stops at the first used entry whose key matches; a miss reads
//   every used entry before the result is given
// throughput: one transaction at a time, set by the single entry memory read port
//   and the one key comparator walking the used entries
// reset: clears the fill count and the control state; entry memory is not swept,
//   since only entries below the fill count are ever compared
`default_nettype none

module multiset_count_table import mct_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mct_in_if.sink     i_in,
    mct_out_if.source  o_out
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic [1:0]             r_state, n_state;
    logic [USED_WIDTH-1:0]  r_used, n_used;
    logic [USED_WIDTH-1:0]  r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [ADDR_WIDTH-1:0]  r_pidx, n_pidx;
    logic                   r_out_valid, n_out_valid;

    logic [KIND_WIDTH-1:0]  r_kind, n_kind;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic                   r_hit, n_hit;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;

    logic                   r_res_added, n_res_added;
    logic [COUNT_WIDTH-1:0] r_res_count, n_res_count;
    logic                   r_res_full, n_res_full;

    logic                   w_issue;
    logic                   w_match;
    logic                   w_out_free;
    logic                   w_we;
    logic [ADDR_WIDTH-1:0]  w_waddr;
    t_entry                 w_wdata;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ever_added = r_res_added;
    assign o_out.count      = r_res_count;
    assign o_out.table_full = r_res_full;

    assign w_issue    = (r_idx < r_used);
    assign w_match    = r_pend && (r_rd_data.key == r_key);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_key       = r_key;
        n_hit       = r_hit;
        n_cnt       = r_cnt;
        n_res_added = r_res_added;
        n_res_count = r_res_count;
        n_res_full  = r_res_full;
        w_we        = 1'b0;
        w_waddr     = r_pidx;
        w_wdata     = '{key: r_key, count: r_cnt};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_key   = i_in.key;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle while the next read is issued
                if (w_match) begin
                    n_hit   = 1'b1;
                    n_cnt   = r_rd_data.count;
                    n_state = S_RESOLVE;
                end else if (!w_issue && !r_pend) begin
                    n_hit   = 1'b0;
                    n_cnt   = '0;
                    n_state = S_RESOLVE;
                end else begin
                    n_pend = w_issue;
                    n_pidx = r_idx[ADDR_WIDTH-1:0];
                    if (w_issue) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_RESOLVE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_res_added = r_hit;
                    n_res_count = r_hit ? r_cnt : '0;
                    n_res_full  = 1'b0;
                    n_state     = S_IDLE;
                    case (r_kind)
                        KIND_ADD: begin
                            if (r_hit) begin
                                w_we          = 1'b1;
                                w_wdata.count = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
                                n_res_count   = w_wdata.count;
                            end else if (r_used != USED_FULL) begin
                                // new key takes the next free entry
                                w_we          = 1'b1;
                                w_waddr       = r_used[ADDR_WIDTH-1:0];
                                w_wdata.count = COUNT_WIDTH'(1);
                                n_used        = r_used + 1'b1;
                                n_res_added   = 1'b1;
                                n_res_count   = COUNT_WIDTH'(1);
                            end else begin
                                n_res_full = 1'b1;
                            end
                        end
                        KIND_DEL: begin
                            if (r_hit) begin
                                w_we          = 1'b1;
                                w_wdata.count = '0;
                            end
                        end
                        default: begin
                            // ask and the unused code change nothing
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_hit       <= n_hit;
        r_cnt       <= n_cnt;
        r_res_added <= n_res_added;
        r_res_count <= n_res_count;
        r_res_full  <= n_res_full;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_idx[ADDR_WIDTH-1:0]];
    end

endmodule

`default_nettype wire
